// ===== src/scrolling_text_marquee_renderer_top_defines.svh =====
// assertion macros for the marquee renderer
`ifndef SCROLLING_TEXT_MARQUEE_RENDERER_TOP_DEFINES_SVH
`define SCROLLING_TEXT_MARQUEE_RENDERER_TOP_DEFINES_SVH
// implication checked on every edge outside reset
`define STM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stm check failed");
// next-cycle implication checked outside reset
`define STM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stm check failed");
`endif

// ===== src/stm_pkg.sv =====
// shared types and constants for the marquee renderer
package stm_pkg;
  localparam int TextDepthDef = 128;
  localparam int MaxBoardsDef = 8;
  localparam int Glyphs       = 96;
  localparam int GlyphAw      = 7;
  localparam int FontAw       = 10;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_TEXT  = 3'd2,
    OP_ROW   = 3'd3,
    OP_WIDTH = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    CFG_FG    = 2'd0,
    CFG_BG    = 2'd1,
    CFG_BOARDS = 2'd2,
    CFG_REV   = 2'd3
  } cfg_idx_t;

  // glyph index of a character code; out-of-range codes use glyph 0
  function automatic logic [GlyphAw-1:0] glyph_of(input logic [7:0] code);
    logic [7:0] g;
    begin
      g = code - 8'd32;
      glyph_of = (code < 8'd32 || code > 8'd127) ? '0 : g[GlyphAw-1:0];
    end
  endfunction
endpackage

// ===== src/scrolling_text_marquee_renderer_top.sv =====
// marquee renderer top: op decode, frame sequencer and output register
// writes, start and idle ticks stay in S_IDLE; a tick renders nb*8 beats, one item at a
// time; a beat runs S_RD, S_WT, then S_COL over each column from 0 up to its own board's,
// back to S_RD and S_WT at each character change, then S_OUT loads the output register
// a frame ends with a pointer advance in S_ADV; output stalls hold the sequencer in S_OUT
// rst_n clears scroll state and registers, then input stalls while the text clears
module scrolling_text_marquee_renderer_top import stm_pkg::*; #(
  parameter int TEXT_DEPTH = TextDepthDef,
  parameter int MAX_BOARDS = MaxBoardsDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_operation,
  input  logic [6:0] in_text_pos,
  input  logic [6:0] in_glyph,
  input  logic [2:0] in_glyph_row,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_board,
  output logic [2:0] out_row,
  output logic [7:0] out_pixel0,
  output logic [7:0] out_pixel1,
  output logic [7:0] out_pixel2,
  output logic [7:0] out_pixel3,
  output logic [7:0] out_pixel4,
  output logic [7:0] out_pixel5,
  output logic [7:0] out_pixel6,
  output logic [7:0] out_pixel7,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  `include "scrolling_text_marquee_renderer_top_defines.svh"
  localparam int Aw = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_RD   = 6'b000010, S_WT   = 6'b000100,
    S_COL  = 6'b001000, S_OUT  = 6'b010000, S_ADV  = 6'b100000
  } st_t;

  st_t st_r;
  logic [7:0] fg_r, bg_r;
  logic [3:0] nbc_r;
  logic       rev_r;
  logic [Aw-1:0] cp_r, pos_r;
  logic [4:0] co_r, col_r;
  logic       act_r;
  logic [2:0] bd_r, r_r, nb_m1;
  logic [5:0] c_r;         // column counter within the row walk
  logic [7:0] bits_r;
  logic [7:0] px_r [8];
  logic       adv_r;       // final advance lookup of char_pointer
  logic       chk_r;       // terminator check after the pointer moved
  logic       ld_r;        // glyph row is loaded on the next column cycle
  logic       ovalid_r;
  logic [2:0] obd_r, orow_r;
  logic       olast_r;
  logic [7:0] opx_r [8];

  logic       acc;
  logic       clr_busy;
  logic       oload;
  logic [Aw-1:0] t_raddr;
  logic [7:0] t_rdata, row_q;
  logic [3:0] wid_q;
  logic [2:0] rr;
  logic [4:0] lim;

  assign cfg_ready = 1'b1;
  assign in_stall  = (st_r != S_IDLE) || clr_busy;
  assign acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= 8'd7; bg_r <= 8'd0; nbc_r <= 4'd1; rev_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FG:     fg_r  <= cfg_data;
        CFG_BG:     bg_r  <= cfg_data;
        CFG_BOARDS: nbc_r <= cfg_data[3:0];
        CFG_REV:    rev_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign nb_m1 = (nbc_r == 4'd0 || nbc_r > 4'(MAX_BOARDS)) ? 3'd0 : 3'(nbc_r - 4'd1);

  logic t_we, r_we, w_we;
  assign t_we = acc && in_operation == OP_TEXT && 32'(in_text_pos) < TEXT_DEPTH;
  assign r_we = acc && in_operation == OP_ROW && 32'(in_glyph) < Glyphs;
  assign w_we = acc && in_operation == OP_WIDTH && 32'(in_glyph) < Glyphs;

  assign t_raddr = adv_r ? cp_r : pos_r;

  stm_text #(.TEXT_DEPTH(TEXT_DEPTH)) u_text (
    .clk, .rst_n, .we(t_we), .waddr(Aw'(in_text_pos)), .wdata(in_value),
    .raddr(t_raddr), .rdata(t_rdata), .busy(clr_busy)
  );

  assign rr = rev_r ? ~r_r : r_r;
  stm_font u_font (
    .clk,
    .row_we(r_we), .row_waddr({in_glyph[6:0], in_glyph_row}), .row_wdata(in_value),
    .wid_we(w_we), .wid_waddr(in_glyph),
    .wid_wdata(in_value > 8'd15 ? 4'd15 : in_value[3:0]),
    .row_raddr({glyph_of(t_rdata), rr}), .wid_raddr(glyph_of(t_rdata)),
    .row_rdata(row_q), .wid_rdata(wid_q)
  );
  assign lim = {1'b0, wid_q} + 5'd1;

  logic first_ld_r;  // first character of the row uses the scroll offset
  logic [Aw-1:0] np, np_cp;
  assign np = (32'(pos_r) + 1 >= TEXT_DEPTH) ? '0 : pos_r + 1'b1;
  assign np_cp = (32'(cp_r) + 1 >= TEXT_DEPTH) ? '0 : cp_r + 1'b1;
  logic [5:0] first_c;
  assign first_c = {bd_r, 3'b000};

  assign oload = (st_r == S_OUT) && (!ovalid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cp_r <= '0; co_r <= '0; act_r <= 1'b0; pos_r <= '0;
      adv_r <= 1'b0; chk_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      if (oload) ovalid_r <= 1'b1;
      else if (!out_stall) ovalid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (acc) begin
          if (in_operation == OP_START) begin
            cp_r <= '0; co_r <= '0; act_r <= 1'b1;
          end else if (in_operation == OP_TICK && act_r) begin
            bd_r <= '0; r_r <= '0; pos_r <= cp_r; first_ld_r <= 1'b1; ld_r <= 1'b1;
            c_r <= '0; st_r <= S_RD;
          end
        end
        S_RD: st_r <= S_WT;  // text read in flight
        S_WT: begin           // font read in flight, text data valid
          if (chk_r) begin
            // pointer moved: scrolling stops on a terminator
            act_r <= (t_rdata != 8'd0);
            adv_r <= 1'b0; chk_r <= 1'b0; st_r <= S_IDLE;
          end else if (adv_r) begin
            st_r <= S_ADV;
          end else begin
            st_r <= S_COL;
          end
        end
        S_COL: begin
          if (ld_r) begin
            ld_r <= 1'b0;
            first_ld_r <= 1'b0;
            if (first_ld_r) begin
              col_r  <= co_r;
              bits_r <= (co_r >= 5'd8) ? 8'd0 : row_q << co_r[2:0];
            end else begin
              col_r  <= '0;
              bits_r <= row_q;
            end
          end else if (col_r <= lim) begin
            if (c_r >= first_c) px_r[c_r[2:0]] <= bits_r[7] ? fg_r : bg_r;
            bits_r <= bits_r << 1;
            col_r  <= col_r + 5'd1;
            if (c_r == first_c + 6'd7) st_r <= S_OUT;
            c_r <= c_r + 6'd1;
          end else begin
            if (t_rdata != 8'd0) pos_r <= np;
            ld_r <= 1'b1;
            st_r <= S_RD;
          end
        end
        S_OUT: if (oload) begin
          obd_r <= bd_r; orow_r <= r_r;
          olast_r <= (bd_r == nb_m1) && (r_r == 3'd7);
          for (int i = 0; i < 8; i++) opx_r[i] <= px_r[i];
          pos_r <= cp_r; first_ld_r <= 1'b1; ld_r <= 1'b1; c_r <= '0;
          r_r <= r_r + 3'd1;
          st_r <= S_RD;
          if (r_r == 3'd7) begin
            if (bd_r == nb_m1) adv_r <= 1'b1;
            else bd_r <= bd_r + 3'd1;
          end
        end
        S_ADV: begin
          // t_rdata/lim describe char_pointer here
          if (co_r + 5'd1 > lim) begin
            co_r <= '0;
            if (t_rdata != 8'd0) begin
              cp_r <= np_cp; chk_r <= 1'b1;
              st_r <= S_RD;  // check the new char for the terminator
            end else begin
              act_r <= 1'b0; adv_r <= 1'b0; st_r <= S_IDLE;
            end
          end else begin
            co_r <= co_r + 5'd1;
            act_r <= (t_rdata != 8'd0);
            adv_r <= 1'b0; st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = ovalid_r;
  assign out_board  = obd_r;
  assign out_row    = orow_r;
  assign out_last   = olast_r;
  assign out_pixel0 = opx_r[0];
  assign out_pixel1 = opx_r[1];
  assign out_pixel2 = opx_r[2];
  assign out_pixel3 = opx_r[3];
  assign out_pixel4 = opx_r[4];
  assign out_pixel5 = opx_r[5];
  assign out_pixel6 = opx_r[6];
  assign out_pixel7 = opx_r[7];

  `STM_ASSERT_IMP(a_stall_busy, st_r != S_IDLE, in_stall)
  `STM_ASSERT_IMP(a_last_row, out_valid && out_last, out_row == 3'd7)
  `STM_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_row))
endmodule

// ===== src/stm_font.sv =====
// font memories: glyph rows and widths, registered synchronous reads
module stm_font import stm_pkg::*; (
  input  logic               clk,
  input  logic               row_we,
  input  logic [FontAw-1:0]  row_waddr,
  input  logic [7:0]         row_wdata,
  input  logic               wid_we,
  input  logic [GlyphAw-1:0] wid_waddr,
  input  logic [3:0]         wid_wdata,
  input  logic [FontAw-1:0]  row_raddr,
  input  logic [GlyphAw-1:0] wid_raddr,
  output logic [7:0]         row_rdata,
  output logic [3:0]         wid_rdata
);
  logic [7:0] row_mem [Glyphs*8];
  logic [3:0] wid_mem [Glyphs];

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_waddr] <= row_wdata;
    if (wid_we) wid_mem[wid_waddr] <= wid_wdata;
    row_rdata <= row_mem[row_raddr];
    wid_rdata <= wid_mem[wid_raddr];
  end
endmodule

// ===== src/stm_text.sv =====
// text memory, cleared one entry per cycle after reset, registered synchronous read
module stm_text import stm_pkg::*; #(
  parameter int TEXT_DEPTH = TextDepthDef,
  localparam int Aw = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [Aw-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [Aw-1:0] raddr,
  output logic [7:0]    rdata,
  output logic          busy
);
  logic [7:0]    mem [TEXT_DEPTH];
  logic [7:0]    q_r;
  logic [Aw-1:0] clr_r;
  logic          clr_act_r;

  // clearing pass after reset: one zero write per cycle until every entry is zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      clr_act_r <= 1'b1;
    end else if (clr_act_r) begin
      clr_r <= clr_r + 1'b1;
      if (32'(clr_r) == TEXT_DEPTH - 1) clr_act_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_act_r) mem[clr_r] <= 8'd0;
    else if (we) mem[waddr] <= wdata;
    q_r <= (we && waddr == raddr) ? wdata : mem[raddr];
  end

  assign rdata = q_r;
  assign busy  = clr_act_r;
endmodule

// ===== dv/tb_scrolling_text_marquee_renderer_top.sv =====
// self-checking testbench for the scrolling text marquee renderer
module tb_scrolling_text_marquee_renderer_top;
  import stm_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int TXT_N = TextDepthDef;
  localparam int SETTLE = 400;

  typedef struct packed {
    logic [2:0]      board;
    logic [2:0]      row;
    logic [7:0][7:0] pix;
    logic            last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_operation = '0;
  logic [6:0] in_text_pos = '0;
  logic [6:0] in_glyph = '0;
  logic [2:0] in_glyph_row = '0;
  logic [7:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_board, out_row;
  logic [7:0] out_pixel0, out_pixel1, out_pixel2, out_pixel3;
  logic [7:0] out_pixel4, out_pixel5, out_pixel6, out_pixel7;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  always #2 clk = ~clk;

  scrolling_text_marquee_renderer_top i_dut (.*);

  // predicted block state
  logic [7:0] txt_mem [TXT_N];
  logic [7:0] font_rows [Glyphs*8];
  logic [3:0] font_w [Glyphs];
  int ptr, coff;
  bit scrolling;
  logic [7:0] fg, bg;
  logic [3:0] boards;
  bit rev;

  beat_t frame_q [$];
  int errors, items, ticks_drawn, beats_seen;
  bit quiet;
  int hold_left;

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $time);
    errors++;
  endtask

  function automatic int glyph_idx(logic [7:0] code);
    return (code < 32 || code > 127) ? 0 : int'(code) - 32;
  endfunction

  function automatic int span_lim(logic [7:0] code);
    return int'(font_w[glyph_idx(code)]) + 1;
  endfunction

  function automatic logic [7:0] row_bits(logic [7:0] code, int r, int sh);
    int rr;
    rr = rev ? (7 - r) : r;
    if (sh >= 8) return 8'h00;
    return font_rows[glyph_idx(code)*8 + rr] << sh;
  endfunction

  // codes whose glyphs are loaded: out-of-range codes, 32 to 35 and 127
  function automatic logic [7:0] safe_code();
    case ($urandom_range(3))
      0: return 8'($urandom_range(0, 31));
      1: return 8'($urandom_range(128, 255));
      2: return 8'd127;
      default: return 8'($urandom_range(32, 35));
    endcase
  endfunction

  function automatic void draw_frame();
    int nb, first, pos, col, lim, c;
    logic [7:0] bits;
    beat_t b;
    nb = (boards == 0 || boards > MaxBoardsDef) ? 1 : int'(boards);
    for (int bd = 0; bd < nb; bd++) begin
      first = bd * 8;
      for (int r = 0; r < 8; r++) begin
        pos = ptr;
        col = coff;
        lim = span_lim(txt_mem[pos]);
        bits = row_bits(txt_mem[pos], r, coff);
        c = 0;
        b = '0;
        b.board = bd[2:0];
        b.row = r[2:0];
        while (c < first + 8) begin
          if (col <= lim) begin
            if (c >= first) b.pix[c-first] = bits[7] ? fg : bg;
            c++;
            col++;
            bits = bits << 1;
          end else begin
            if (txt_mem[pos] != 0) pos = (pos + 1) % TXT_N;
            lim = span_lim(txt_mem[pos]);
            bits = row_bits(txt_mem[pos], r, 0);
            col = 0;
          end
        end
        b.last = (bd + 1 == nb && r == 7);
        frame_q.push_back(b);
      end
    end
    coff++;
    if (coff > span_lim(txt_mem[ptr])) begin
      coff = 0;
      if (txt_mem[ptr] != 0) ptr = (ptr + 1) % TXT_N;
    end
    if (txt_mem[ptr] == 0) scrolling = 0;
    ticks_drawn++;
  endfunction

  function automatic void predict_item(logic [2:0] op, logic [6:0] pos, logic [6:0] g,
                                       logic [2:0] gr, logic [7:0] val);
    case (op)
      OP_START: begin
        ptr = 0;
        coff = 0;
        scrolling = 1;
      end
      OP_TEXT: txt_mem[pos] = val;
      OP_ROW: if (g < Glyphs) font_rows[g*8 + gr] = val;
      OP_WIDTH: if (g < Glyphs) font_w[g] = (val > 15) ? 4'd15 : val[3:0];
      OP_TICK: if (scrolling) draw_frame();
      default: ;
    endcase
  endfunction

  task automatic put_item(logic [2:0] op, logic [6:0] pos, logic [6:0] g,
                          logic [2:0] gr, logic [7:0] val);
    bit took;
    in_valid <= 1'b1;
    in_operation <= op;
    in_text_pos <= pos;
    in_glyph <= g;
    in_glyph_row <= gr;
    in_value <= val;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    predict_item(op, pos, g, gr, val);
    items++;
    if (!quiet && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // other fields random so every input bit toggles
  task automatic put_op(logic [2:0] op);
    put_item(op, 7'($urandom), 7'($urandom), 3'($urandom), 8'($urandom));
  endtask

  task automatic put_char(int pos, logic [7:0] code);
    put_item(OP_TEXT, pos[6:0], 7'($urandom), 3'($urandom), code);
  endtask

  // block is idle: no frame pending, then let it settle
  task automatic drain();
    int n;
    in_valid <= 1'b0;
    n = 0;
    while (frame_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] d);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FG: fg = d;
      CFG_BG: bg = d;
      CFG_BOARDS: boards = d[3:0];
      CFG_REV: rev = d[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic [7:0] f, logic [7:0] b, logic [3:0] nb, bit rv);
    drain();
    write_reg(CFG_FG, f);
    write_reg(CFG_BG, b);
    write_reg(CFG_BOARDS, {4'd0, nb});
    write_reg(CFG_REV, {7'd0, rv});
  endtask

  // result side: random stall, or a long counted hold
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 10);
      end
    end
  end

  // accepted beat is checked against the oldest predicted one
  initial begin
    beat_t w;
    logic [7:0] got_pix [8];
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        beats_seen++;
        if (frame_q.size() == 0) begin
          $display("unexpected beat board %0d row %0d (t=%0t)", out_board, out_row, $time);
          errors++;
        end else begin
          w = frame_q.pop_front();
          got_pix = '{out_pixel0, out_pixel1, out_pixel2, out_pixel3,
                      out_pixel4, out_pixel5, out_pixel6, out_pixel7};
          if (out_board !== w.board) report("board", out_board, w.board);
          if (out_row !== w.row) report("row", out_row, w.row);
          for (int i = 0; i < 8; i++)
            if (got_pix[i] !== w.pix[i]) report($sformatf("pixel%0d", i), got_pix[i], w.pix[i]);
          if (out_last !== w.last) report("last", out_last, w.last);
        end
      end
    end
  end

  // only the glyphs that the text may use are loaded
  task automatic test_font_load();
    int gl [5] = '{0, 1, 2, 3, 95};
    foreach (gl[j]) begin
      for (int r = 0; r < 8; r++)
        put_item(OP_ROW, 7'($urandom), gl[j][6:0], r[2:0],
                 (gl[j] == 1) ? 8'hFF : 8'($urandom));
      put_item(OP_WIDTH, 7'($urandom), gl[j][6:0], 3'($urandom),
               (gl[j] == 1) ? 8'd200 : 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic test_directed();
    put_op(OP_TICK);                         // idle tick
    put_op(OP_START);                        // empty text: one frame then idle
    put_op(OP_TICK);
    put_op(OP_TICK);
    for (logic [2:0] op = OP_SPARE_LO; op <= OP_SPARE_HI && op >= OP_SPARE_LO; op++) begin
      put_op(op);
      if (op == OP_SPARE_HI) break;
    end
    put_item(OP_ROW, 7'd0, 7'd100, 3'd7, 8'hAA);  // glyph beyond font ignored
    put_item(OP_WIDTH, 7'd0, 7'd127, 3'd0, 8'hFF);
    put_item(OP_WIDTH, 7'd0, 7'd95, 3'd0, 8'd16);   // saturates at 15
    put_char(0, 8'd33);
    put_char(1, 8'd127);
    put_char(2, 8'd10);
    put_char(3, 8'd200);
    put_char(4, 8'd0);
    set_regs(8'hFF, 8'h00, 4'd8, 1'b1);
    put_op(OP_START);
    repeat (3) put_op(OP_TICK);
    set_regs(8'h00, 8'hFF, 4'd0, 1'b0);
    put_op(OP_START);
    put_op(OP_TICK);
    put_op(OP_START);                        // restart mid-scroll
    put_op(OP_TICK);
    set_regs(8'h5A, 8'hA5, 4'd15, 1'b1);
    put_op(OP_TICK);
    set_regs(8'h07, 8'h00, 4'd9, 1'b0);
    put_op(OP_TICK);
  endtask

  // a long stretch with no idle cycles on either side
  task automatic test_no_idle();
    drain();
    quiet = 1;
    for (int p = 0; p < 6; p++) put_char(p, safe_code());
    put_char(6, 8'd0);
    put_op(OP_START);
    repeat (24) put_op(OP_TICK);
    quiet = 0;
    drain();
  endtask

  task automatic test_pressure();
    set_regs(8'h11, 8'h22, 4'd2, 1'b1);
    hold_left = 1500;
    put_op(OP_START);
    repeat (8) put_op(OP_TICK);
  endtask

  task automatic test_random();
    int len, nb;
    for (int seg = 0; seg < 6; seg++) begin
      nb = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      set_regs(8'($urandom), 8'($urandom), nb[3:0], 1'($urandom_range(1)));
      len = $urandom_range(1, 8);
      for (int p = 0; p < len; p++) put_char(p, safe_code());
      put_char(len, 8'd0);
      put_op(OP_START);
      for (int k = 0; k < 10; k++) begin
        case ($urandom_range(19))
          0, 1: put_char($urandom_range(0, 127), safe_code());
          2: put_item(OP_ROW, 7'($urandom), 7'($urandom), 3'($urandom), 8'($urandom));
          3: put_item(OP_WIDTH, 7'($urandom), 7'($urandom), 3'($urandom), 8'($urandom));
          4: put_op(OP_START);
          5: put_op(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)));
          default: put_op(OP_TICK);
        endcase
      end
    end
  endtask

  initial begin
    foreach (txt_mem[i]) txt_mem[i] = '0;
    foreach (font_rows[i]) font_rows[i] = '0;
    foreach (font_w[i]) font_w[i] = '0;
    ptr = 0;
    coff = 0;
    scrolling = 0;
    fg = 8'd7;
    bg = 8'd0;
    boards = 4'd1;
    rev = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_font_load();
    test_directed();
    test_no_idle();
    test_pressure();
    test_random();
    drain();
    $display("run covered %0d input beats, %0d rendered frames, %0d output beats",
             items, ticks_drawn, beats_seen);
    $display("font loads, all ops and registers, no-idle stretch, long output hold, random scrolls");
    if (errors == 0 && frame_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
